FILE: hw/rtl/encs_pkg.sv
// encs_pkg: shared types, codes and helper functions of the elastic-net solver.
// Used by the interfaces, the controller, the datapath and the top level.
package encs_pkg;

    localparam int VALUE_W   = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LASSO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIDGE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 3'd5;

    // input item opcodes
    localparam logic [1:0] OP_FEATURE = 2'd0;
    localparam logic [1:0] OP_TARGET  = 2'd1;
    localparam logic [1:0] OP_RUN     = 2'd2;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_RUN_INIT,
        DP_SWEEP_INIT,
        DP_RES_MUL,
        DP_RES_ACC,
        DP_RES_WR,
        DP_BIAS_DIV,
        DP_BIAS_SET,
        DP_CF_INIT,
        DP_CF_M1,
        DP_CF_T,
        DP_CF_M2,
        DP_CF_M3,
        DP_CF_ACC,
        DP_CF_DIV,
        DP_CF_UPD,
        DP_SWEEP_END,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit_bias;
    } dp_cmd_t;

    typedef struct packed {
        logic        conv_hit;
        logic        div_done;
        logic        out_free;
        logic [15:0] lim_m1;
    } dp_stat_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } clamp_t;

    function automatic clamp_t clamp32(input logic signed [79:0] v);
        clamp_t r;
        begin
            if (v > 80'sd2147483647)
            begin
                r.sat = 1'b1;
                r.val = 32'sh7FFFFFFF;
            end
            else if (v < -80'sd2147483648)
            begin
                r.sat = 1'b1;
                r.val = 32'sh80000000;
            end
            else
            begin
                r.sat = 1'b0;
                r.val = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/encs_in_if.sv
// encs_in_if: valid/ready channel carrying one load or run item.
// Depends on encs_pkg for the value width.
interface encs_in_if import encs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic [7:0]                row;
    logic [2:0]                column;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, op, row, column, value, input ready);
    modport sink   (input valid, op, row, column, value, output ready);
endinterface

FILE: hw/rtl/encs_out_if.sv
// encs_out_if: valid/ready channel carrying one coefficient or bias result.
// Depends on encs_pkg for the value width.
interface encs_out_if import encs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [3:0]                slot;
    logic signed [VALUE_W-1:0] result_value;
    logic                      converged;
    logic                      saturated;
    logic                      last;

    modport source (output valid, slot, result_value, converged, saturated, last,
                    input ready);
    modport sink   (input valid, slot, result_value, converged, saturated, last,
                    output ready);
endinterface

FILE: hw/rtl/elastic_net_coordinate_solver.sv
// elastic_net_coordinate_solver: top level, joins controller and datapath.
// Depends on encs_pkg, encs_in_if, encs_out_if, encs_ctrl, encs_dp.
//
//  channel  kind          transaction carries
//  item     valid/ready   op, row, column, value (load feature, load target, run)
//  result   valid/ready   slot, result_value, converged, saturated, last
//  cfg      write only    cfg_we, cfg_index, cfg_data
//
// Load transactions are accepted while the solver is idle. Each sweep of a run is paced
// by the single multiplier and the bit-serial divider; the run then ends with
// nf+1 result transactions.
// Items are accepted only while no run is in progress; a stalled result
// holds the run in its emit phase. Reset is asynchronous, active low.
module elastic_net_coordinate_solver import encs_pkg::*; #(
    parameter int MAX_SAMPLES  = 256,
    parameter int MAX_FEATURES = 8,
    parameter int FRAC_BITS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    encs_in_if.sink              item,
    encs_out_if.source           result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int SW = $clog2(MAX_SAMPLES);
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    dp_cmd_t       cmd;
    dp_stat_t      stat;
    logic [SW-1:0] row_idx, ns_m1;
    logic [FW-1:0] col_idx, nf_m1;
    logic          idle;
    logic          item_fire;

    assign item.ready = idle;
    assign item_fire  = item.valid && idle;

    encs_ctrl #(.SW(SW), .FW(FW)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_fire (item_fire),
        .item_op   (item.op),
        .stat      (stat),
        .ns_m1     (ns_m1),
        .nf_m1     (nf_m1),
        .cmd       (cmd),
        .row_idx   (row_idx),
        .col_idx   (col_idx),
        .idle      (idle)
    );

    encs_dp #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_FEATURES (MAX_FEATURES),
        .FRAC_BITS    (FRAC_BITS),
        .SW           (SW),
        .FW           (FW)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .item_fire        (item_fire),
        .item_op          (item.op),
        .item_row         (item.row),
        .item_column      (item.column),
        .item_value       (item.value),
        .cmd              (cmd),
        .row_idx          (row_idx),
        .col_idx          (col_idx),
        .result_ready     (result.ready),
        .result_valid     (result.valid),
        .result_slot      (result.slot),
        .result_value     (result.result_value),
        .result_converged (result.converged),
        .result_saturated (result.saturated),
        .result_last      (result.last),
        .stat             (stat),
        .ns_m1            (ns_m1),
        .nf_m1            (nf_m1)
    );
endmodule

FILE: hw/rtl/encs_div.sv
// encs_div: restoring shift-subtract divider, one quotient bit per cycle.
// Optional fraction shift of the dividend; no package dependency beyond types.
module encs_div import encs_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    frac,
    input  logic [63:0]             dividend,
    input  logic [63:0]             divisor,
    output logic                    done,
    output logic [64+FRAC_BITS-1:0] quot
);
    localparam int DW = 64 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [64:0]   rem_reg;
    logic [DW-1:0] dvd_reg;
    logic [63:0]   dsr_reg;

    logic [64:0] rem_sh;
    logic [65:0] diff;
    logic        ge;

    assign rem_sh = {rem_reg[63:0], dvd_reg[DW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};
    assign ge     = ~diff[65];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            dvd_reg <= frac ? {dividend, {FRAC_BITS{1'b0}}} : DW'(dividend);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[64:0] : rem_sh;
            dvd_reg <= {dvd_reg[DW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = dvd_reg;
endmodule

FILE: hw/rtl/encs_ctrl.sv
// encs_ctrl: sequencer for load, sweep and emit phases of the solver.
// Depends on encs_pkg for command and status types.
module encs_ctrl import encs_pkg::*; #(
    parameter int SW = 8,
    parameter int FW = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_fire,
    input  logic [1:0]    item_op,
    input  dp_stat_t      stat,
    input  logic [SW-1:0] ns_m1,
    input  logic [FW-1:0] nf_m1,
    output dp_cmd_t       cmd,
    output logic [SW-1:0] row_idx,
    output logic [FW-1:0] col_idx,
    output logic          idle
);
    typedef enum logic [21:0] {
        S_IDLE     = 22'h000001,
        S_RUN_INIT = 22'h000002,
        S_SW_INIT  = 22'h000004,
        S_R_RD     = 22'h000008,
        S_R_MUL    = 22'h000010,
        S_R_ACC    = 22'h000020,
        S_R_WR     = 22'h000040,
        S_B_DIV    = 22'h000080,
        S_B_WAIT   = 22'h000100,
        S_B_SET    = 22'h000200,
        S_C_INIT   = 22'h000400,
        S_C_RD     = 22'h000800,
        S_C_M1     = 22'h001000,
        S_C_T      = 22'h002000,
        S_C_M2     = 22'h004000,
        S_C_M3     = 22'h008000,
        S_C_ACC    = 22'h010000,
        S_C_DIV    = 22'h020000,
        S_C_WAIT   = 22'h040000,
        S_C_UPD    = 22'h080000,
        S_SW_END   = 22'h100000,
        S_EMIT     = 22'h200000
    } state_t;

    state_t        state_reg, state_next;
    logic [SW-1:0] row_reg, row_next;
    logic [FW-1:0] col_reg, col_next;
    logic [15:0]   sweep_reg, sweep_next;
    logic          bias_phase_reg, bias_phase_next;

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        sweep_next      = sweep_reg;
        bias_phase_next = bias_phase_reg;
        cmd.op          = DP_NOP;
        cmd.emit_bias   = bias_phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire && item_op == OP_RUN)
                    state_next = S_RUN_INIT;
            end
            S_RUN_INIT:
            begin
                cmd.op     = DP_RUN_INIT;
                sweep_next = '0;
                state_next = S_SW_INIT;
            end
            S_SW_INIT:
            begin
                cmd.op     = DP_SWEEP_INIT;
                row_next   = '0;
                col_next   = '0;
                state_next = S_R_RD;
            end
            S_R_RD:  state_next = S_R_MUL;
            S_R_MUL:
            begin
                cmd.op     = DP_RES_MUL;
                state_next = S_R_ACC;
            end
            S_R_ACC:
            begin
                cmd.op = DP_RES_ACC;
                if (col_reg == nf_m1)
                    state_next = S_R_WR;
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = S_R_RD;
                end
            end
            S_R_WR:
            begin
                cmd.op   = DP_RES_WR;
                col_next = '0;
                if (row_reg == ns_m1)
                begin
                    row_next   = '0;
                    state_next = S_B_DIV;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_R_RD;
                end
            end
            S_B_DIV:
            begin
                cmd.op     = DP_BIAS_DIV;
                state_next = S_B_WAIT;
            end
            S_B_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_B_SET;
            end
            S_B_SET:
            begin
                cmd.op     = DP_BIAS_SET;
                state_next = S_C_INIT;
            end
            S_C_INIT:
            begin
                cmd.op     = DP_CF_INIT;
                row_next   = '0;
                state_next = S_C_RD;
            end
            S_C_RD:  state_next = S_C_M1;
            S_C_M1:
            begin
                cmd.op     = DP_CF_M1;
                state_next = S_C_T;
            end
            S_C_T:
            begin
                cmd.op     = DP_CF_T;
                state_next = S_C_M2;
            end
            S_C_M2:
            begin
                cmd.op     = DP_CF_M2;
                state_next = S_C_M3;
            end
            S_C_M3:
            begin
                cmd.op     = DP_CF_M3;
                state_next = S_C_ACC;
            end
            S_C_ACC:
            begin
                cmd.op = DP_CF_ACC;
                if (row_reg == ns_m1)
                begin
                    row_next   = '0;
                    state_next = S_C_DIV;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_C_RD;
                end
            end
            S_C_DIV:
            begin
                cmd.op     = DP_CF_DIV;
                state_next = S_C_WAIT;
            end
            S_C_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_C_UPD;
            end
            S_C_UPD:
            begin
                cmd.op = DP_CF_UPD;
                if (col_reg == nf_m1)
                    state_next = S_SW_END;
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = S_C_INIT;
                end
            end
            S_SW_END:
            begin
                cmd.op = DP_SWEEP_END;
                if (stat.conv_hit || sweep_reg == stat.lim_m1)
                begin
                    col_next        = '0;
                    bias_phase_next = 1'b0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                    state_next = S_SW_INIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op = DP_EMIT;
                    if (bias_phase_reg)
                        state_next = S_IDLE;
                    else if (col_reg == nf_m1)
                        bias_phase_next = 1'b1;
                    else
                        col_next = col_reg + 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            row_reg        <= '0;
            col_reg        <= '0;
            sweep_reg      <= '0;
            bias_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            sweep_reg      <= sweep_next;
            bias_phase_reg <= bias_phase_next;
        end
    end

    assign row_idx = row_reg;
    assign col_idx = col_reg;
    assign idle    = (state_reg == S_IDLE);
endmodule

FILE: hw/rtl/encs_dp.sv
// encs_dp: stores, config registers, multiplier, accumulators and result register.
// Depends on encs_pkg and instantiates encs_div.
module encs_dp import encs_pkg::*; #(
    parameter int MAX_SAMPLES  = 256,
    parameter int MAX_FEATURES = 8,
    parameter int FRAC_BITS    = 16,
    parameter int SW           = 8,
    parameter int FW           = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      item_fire,
    input  logic [1:0]                item_op,
    input  logic [7:0]                item_row,
    input  logic [2:0]                item_column,
    input  logic signed [VALUE_W-1:0] item_value,
    input  dp_cmd_t                   cmd,
    input  logic [SW-1:0]             row_idx,
    input  logic [FW-1:0]             col_idx,
    input  logic                      result_ready,
    output logic                      result_valid,
    output logic [3:0]                result_slot,
    output logic signed [VALUE_W-1:0] result_value,
    output logic                      result_converged,
    output logic                      result_saturated,
    output logic                      result_last,
    output dp_stat_t                  stat,
    output logic [SW-1:0]             ns_m1,
    output logic [FW-1:0]             nf_m1
);
    localparam int FDEPTH = MAX_SAMPLES * (1 << FW);
    localparam int DW     = 64 + FRAC_BITS;

    // configuration
    logic [30:0] lasso_reg, ridge_reg, thresh_reg;
    logic [8:0]  samples_reg;
    logic [3:0]  features_reg;
    logic [15:0] sweeps_reg;

    // stores
    logic signed [31:0] fmem [FDEPTH];
    logic signed [31:0] tmem [MAX_SAMPLES];
    logic signed [31:0] rmem [MAX_SAMPLES];
    logic signed [31:0] fmem_q, tmem_q, rmem_q;

    logic signed [31:0] coef_reg [MAX_FEATURES];
    logic signed [31:0] bias_reg, old_bias_reg;
    logic               sat_reg, conv_reg, div_neg_reg, out_valid_reg;

    logic signed [63:0] prod_reg, acc_reg, sum_reg, num_reg, den_reg;
    logic signed [31:0] x_reg, t_reg;

    logic [3:0]         slot_reg;
    logic signed [31:0] val_reg;
    logic               conv_out_reg, sat_out_reg, last_out_reg;

    logic [31:0] ns_ext, nf_ext;
    logic        row_ok, col_ok;

    logic signed [31:0] coef_cur;
    logic signed [63:0] prod_sh;
    clamp_t             res_c, t_c, newc_c;
    logic [63:0]        num_mag, adj_mag, sum_mag;
    logic signed [63:0] num_adj;
    logic               div_start, div_frac, div_done;
    logic [63:0]        div_a, div_d;
    logic [DW-1:0]      quot;
    logic               q_over;
    logic signed [31:0] q32, bias_q;
    logic signed [34:0] dq;
    logic signed [37:0] s7, step;
    logic signed [32:0] bdiff;
    logic [32:0]        babs;
    logic               out_free;

    // effective counts
    always_comb
    begin
        if (samples_reg == '0)
            ns_ext = 32'd1;
        else if ({23'b0, samples_reg} > 32'(MAX_SAMPLES))
            ns_ext = 32'(MAX_SAMPLES);
        else
            ns_ext = {23'b0, samples_reg};
        if (features_reg == '0)
            nf_ext = 32'd1;
        else if ({28'b0, features_reg} > 32'(MAX_FEATURES))
            nf_ext = 32'(MAX_FEATURES);
        else
            nf_ext = {28'b0, features_reg};
    end

    assign ns_m1       = SW'(ns_ext - 32'd1);
    assign nf_m1       = FW'(nf_ext - 32'd1);
    assign stat.lim_m1 = (sweeps_reg == '0) ? 16'd0 : sweeps_reg - 16'd1;

    assign row_ok = {24'b0, item_row} < 32'(MAX_SAMPLES);
    assign col_ok = {29'b0, item_column} < 32'(MAX_FEATURES);

    // arithmetic
    assign coef_cur = coef_reg[col_idx];
    assign prod_sh  = prod_reg >>> FRAC_BITS;
    assign res_c    = clamp32(80'(tmem_q) - 80'(acc_reg));
    assign t_c      = clamp32(80'(rmem_q) + 80'(prod_sh) - 80'(bias_reg));

    assign num_mag = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
    always_comb
    begin
        if (num_mag > {33'b0, lasso_reg})
        begin
            if (coef_cur > 32'sd0)
                num_adj = num_reg - $signed({33'b0, lasso_reg});
            else if (coef_cur < 32'sd0)
                num_adj = num_reg + $signed({33'b0, lasso_reg});
            else
                num_adj = num_reg;
        end
        else
            num_adj = '0;
    end
    assign adj_mag = num_adj[63] ? 64'(-num_adj) : 64'(num_adj);
    assign sum_mag = sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg);

    assign div_start = (cmd.op == DP_BIAS_DIV) || (cmd.op == DP_CF_DIV);
    assign div_frac  = (cmd.op == DP_CF_DIV);
    assign div_a     = div_frac ? adj_mag : sum_mag;
    assign div_d     = div_frac ? 64'(den_reg) : {32'b0, ns_ext};

    encs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .frac     (div_frac),
        .dividend (div_a),
        .divisor  (div_d),
        .done     (div_done),
        .quot     (quot)
    );

    // quotient limit: 2^31 for a negative result, 2^31-1 otherwise
    assign q_over = div_neg_reg ? (quot > DW'(64'h80000000)) : (quot > DW'(64'h7FFFFFFF));
    always_comb
    begin
        if (den_reg == '0)
            q32 = '0;
        else if (q_over)
            q32 = div_neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            q32 = div_neg_reg ? -$signed(quot[31:0]) : $signed(quot[31:0]);
    end
    assign bias_q = div_neg_reg ? -$signed(quot[31:0]) : $signed(quot[31:0]);

    // over-relaxed step: floor(7*(q - c) / 2)
    assign dq     = 35'(q32) - 35'(coef_cur);
    assign s7     = (38'(dq) <<< 3) - 38'(dq);
    assign step   = s7 >>> 1;
    assign newc_c = clamp32(80'(coef_cur) + 80'(step));

    assign bdiff         = 33'(bias_reg) - 33'(old_bias_reg);
    assign babs          = bdiff[32] ? 33'(-bdiff) : 33'(bdiff);
    assign stat.conv_hit = babs <= {2'b0, thresh_reg};
    assign stat.div_done = div_done;

    assign out_free      = !out_valid_reg || result_ready;
    assign stat.out_free = out_free;

    // stores: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (item_fire && item_op == OP_FEATURE && row_ok && col_ok)
            fmem[{SW'(item_row), FW'(item_column)}] <= item_value;
        fmem_q <= fmem[{row_idx, col_idx}];
        if (item_fire && item_op == OP_TARGET && row_ok)
            tmem[SW'(item_row)] <= item_value;
        tmem_q <= tmem[row_idx];
        if (cmd.op == DP_RES_WR)
            rmem[row_idx] <= res_c.val;
        rmem_q <= rmem[row_idx];
    end

    // control state and persistent solution
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lasso_reg     <= '0;
            ridge_reg     <= '0;
            samples_reg   <= 9'd256;
            features_reg  <= 4'd8;
            sweeps_reg    <= 16'd1000;
            thresh_reg    <= '0;
            for (int k = 0; k < MAX_FEATURES; k++)
                coef_reg[k] <= '0;
            bias_reg      <= '0;
            sat_reg       <= 1'b0;
            conv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            div_neg_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LASSO:    lasso_reg    <= cfg_data;
                    CFG_RIDGE:    ridge_reg    <= cfg_data;
                    CFG_SAMPLES:  samples_reg  <= cfg_data[8:0];
                    CFG_FEATURES: features_reg <= cfg_data[3:0];
                    CFG_SWEEPS:   sweeps_reg   <= cfg_data[15:0];
                    CFG_THRESH:   thresh_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == DP_EMIT)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                DP_RUN_INIT:
                begin
                    sat_reg  <= 1'b0;
                    conv_reg <= 1'b0;
                end
                DP_RES_WR:
                    sat_reg <= sat_reg | res_c.sat;
                DP_BIAS_DIV:
                    div_neg_reg <= sum_reg[63];
                DP_BIAS_SET:
                    bias_reg <= bias_q;
                DP_CF_T:
                    sat_reg <= sat_reg | t_c.sat;
                DP_CF_DIV:
                    div_neg_reg <= num_adj[63];
                DP_CF_UPD:
                begin
                    coef_reg[col_idx] <= newc_c.val;
                    sat_reg <= sat_reg | newc_c.sat | ((den_reg != '0) && q_over);
                end
                DP_SWEEP_END:
                    conv_reg <= stat.conv_hit;
                default: ;
            endcase
        end
    end

    // accumulators and result payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_SWEEP_INIT:
            begin
                sum_reg      <= '0;
                acc_reg      <= '0;
                old_bias_reg <= bias_reg;
            end
            DP_RES_MUL: prod_reg <= 64'(fmem_q) * 64'(coef_cur);
            DP_RES_ACC: acc_reg  <= acc_reg + prod_sh;
            DP_RES_WR:
            begin
                sum_reg <= sum_reg + 64'(res_c.val);
                acc_reg <= '0;
            end
            DP_CF_INIT:
            begin
                num_reg <= '0;
                den_reg <= $signed({33'b0, ridge_reg});
            end
            DP_CF_M1:
            begin
                x_reg    <= fmem_q;
                prod_reg <= 64'(fmem_q) * 64'(coef_cur);
            end
            DP_CF_T:  t_reg    <= t_c.val;
            DP_CF_M2: prod_reg <= 64'(x_reg) * 64'(t_reg);
            DP_CF_M3:
            begin
                num_reg  <= num_reg + prod_sh;
                prod_reg <= 64'(x_reg) * 64'(x_reg);
            end
            DP_CF_ACC: den_reg <= den_reg + prod_sh;
            DP_EMIT:
            begin
                slot_reg     <= cmd.emit_bias ? 4'(MAX_FEATURES) : 4'(col_idx);
                val_reg      <= cmd.emit_bias ? bias_reg : coef_cur;
                conv_out_reg <= conv_reg;
                sat_out_reg  <= sat_reg;
                last_out_reg <= cmd.emit_bias;
            end
            default: ;
        endcase
    end

    assign result_valid     = out_valid_reg;
    assign result_slot      = slot_reg;
    assign result_value     = val_reg;
    assign result_converged = conv_out_reg;
    assign result_saturated = sat_out_reg;
    assign result_last      = last_out_reg;
endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// testbench: checks elastic_net_coordinate_solver against a fixed-point predictor
// of its coordinate-descent runs. Depends on encs_pkg, encs_in_if, encs_out_if.
module testbench;
    import encs_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 200000;
    localparam int LONG_HOLD  = 3000;

    typedef struct {
        logic [1:0]         op;
        logic [7:0]         row;
        logic [2:0]         column;
        logic signed [31:0] value;
    } load_item_t;

    typedef struct {
        logic [3:0]         slot;
        logic signed [31:0] value;
        logic               converged;
        logic               saturated;
        logic               last;
    } solver_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    encs_in_if  item ();
    encs_out_if result ();

    elastic_net_coordinate_solver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item.sink),
        .result    (result.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // predictor state
    int     feat_mem [0:2047];
    int     target_mem [0:255];
    int     resid_mem [0:255];
    int     coef [0:7];
    int     bias_q;
    longint lasso_w, ridge_w, thresh_w;
    int     samples_reg, features_reg, sweeps_reg;
    bit     run_sat;

    load_item_t     queued_items[$];
    solver_result_t results_due[$];

    bit calm;
    int errors;
    int results_seen;
    int idle_cycles;

    function automatic longint mul_q(int a, int b);
        return (longint'(a) * longint'(b)) >>> 16;
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647)
        begin
            run_sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            run_sat = 1'b1;
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    function automatic int div_q(longint num, longint den);
        longint unsigned a, d, q, r;
        bit neg;
        if (den <= 0)
            return 0;
        neg = num < 0;
        d = den;
        a = neg ? -num : num;
        q = a / d;
        r = a % d;
        if (q >= 64'd4294967296)
        begin
            run_sat = 1'b1;
            return neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        for (int k = 0; k < 16; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 1;
            end
        end
        if (q > 64'd2147483647 + (neg ? 1 : 0))
        begin
            run_sat = 1'b1;
            return neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        return neg ? int'(-longint'(q)) : int'(q);
    endfunction

    task automatic descend_once(int ns, int nf);
        longint sum, acc, num, den, mag, step;
        int c_old, x, t, q;
        sum = 0;
        for (int n = 0; n < ns; n++)
        begin
            acc = 0;
            for (int i = 0; i < nf; i++)
                acc += mul_q(feat_mem[n*8+i], coef[i]);
            resid_mem[n] = sat32(longint'(target_mem[n]) - acc);
            sum += resid_mem[n];
        end
        bias_q = int'(sum / longint'(ns));
        for (int i = 0; i < nf; i++)
        begin
            c_old = coef[i];
            num = 0;
            den = ridge_w;
            for (int n = 0; n < ns; n++)
            begin
                x = feat_mem[n*8+i];
                t = sat32(longint'(resid_mem[n]) + mul_q(c_old, x) - bias_q);
                num += mul_q(x, t);
                den += mul_q(x, x);
            end
            mag = num < 0 ? -num : num;
            if (mag > lasso_w)
            begin
                if (c_old > 0)
                    num -= lasso_w;
                else if (c_old < 0)
                    num += lasso_w;
            end
            else
                num = 0;
            q = div_q(num, den);
            step = (7 * (longint'(q) - c_old)) >>> 1;
            coef[i] = sat32(longint'(c_old) + step);
        end
    endtask

    task automatic solve_run();
        int ns, nf, lim;
        longint prev, diff;
        bit conv;
        solver_result_t r;
        ns = samples_reg == 0 ? 1 : (samples_reg > 256 ? 256 : samples_reg);
        nf = features_reg == 0 ? 1 : (features_reg > 8 ? 8 : features_reg);
        lim = sweeps_reg == 0 ? 1 : sweeps_reg;
        run_sat = 1'b0;
        conv = 1'b0;
        for (int s = 0; s < lim; s++)
        begin
            prev = bias_q;
            descend_once(ns, nf);
            diff = longint'(bias_q) - prev;
            if (diff < 0)
                diff = -diff;
            if (diff <= thresh_w)
            begin
                conv = 1'b1;
                break;
            end
        end
        for (int i = 0; i <= nf; i++)
        begin
            r.slot = 4'((i < nf) ? i : 8);
            r.value = (i < nf) ? coef[i] : bias_q;
            r.converged = conv;
            r.saturated = run_sat;
            r.last = (i == nf);
            results_due.push_back(r);
        end
    endtask

    task automatic apply_item(load_item_t it);
        case (it.op)
            OP_FEATURE: feat_mem[it.row*8 + it.column] = it.value;
            OP_TARGET:  target_mem[it.row] = it.value;
            OP_RUN:     solve_run();
            default: ;
        endcase
    endtask

    // sender: bursts of random length with random gaps
    int burst_left, gap_left;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item.valid && item.ready)
            begin
                apply_item(queued_items.pop_front());
            end
            if (!(item.valid && !item.ready))
            begin
                if (gap_left > 0 && !calm)
                begin
                    gap_left--;
                    item.valid <= 1'b0;
                end
                else if (queued_items.size() > 0)
                begin
                    item.valid  <= 1'b1;
                    item.op     <= queued_items[0].op;
                    item.row    <= queued_items[0].row;
                    item.column <= queued_items[0].column;
                    item.value  <= queued_items[0].value;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = $urandom_range(1, 6);
                    end
                end
                else
                    item.valid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern, one long hold-off after some results
    logic [15:0] stall_pat;
    int hold_cnt;
    bit long_done;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                result.ready <= 1'b0;
            end
            else if (!long_done && results_seen >= 20)
            begin
                long_done = 1'b1;
                hold_cnt = LONG_HOLD;
                result.ready <= 1'b0;
            end
            else if (calm)
                result.ready <= 1'b1;
            else
            begin
                if ($urandom_range(0, 31) == 0)
                    stall_pat = $urandom();
                stall_pat = {stall_pat[14:0], stall_pat[15]};
                result.ready <= stall_pat[0] | stall_pat[3];
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            results_seen++;
            if (results_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: slot %0d value %0d", result.slot,
                             result.result_value);
            end
            else
            begin
                solver_result_t e;
                e = results_due.pop_front();
                if (e.slot !== result.slot || e.value !== result.result_value ||
                    e.converged !== result.converged || e.saturated !== result.saturated ||
                    e.last !== result.last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp slot %0d val %0d conv %0b sat %0b last %0b",
                                  " / got slot %0d val %0d conv %0b sat %0b last %0b"},
                                 e.slot, e.value, e.converged, e.saturated, e.last,
                                 result.slot, result.result_value, result.converged,
                                 result.saturated, result.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'sh7FFFFFFF;
            2: return 32'sh80000000;
            3: return 32'sd0;
            default: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
        endcase
    endfunction

    function automatic logic [30:0] pick_weight();
        case ($urandom_range(0, 3))
            0: return 31'd0;
            1: return 31'($urandom_range(0, 32'h800));
            2: return 31'($urandom_range(0, 32'h20000));
            default: return 31'($urandom());
        endcase
    endfunction

    task automatic push_item(logic [1:0] op, logic [7:0] row, logic [2:0] column,
                             logic signed [31:0] value);
        load_item_t it;
        it.op = op;
        it.row = row;
        it.column = column;
        it.value = value;
        queued_items.push_back(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_LASSO:    lasso_w = data;
            CFG_RIDGE:    ridge_w = data;
            CFG_SAMPLES:  samples_reg = data & 31'h1FF;
            CFG_FEATURES: features_reg = data & 31'hF;
            CFG_SWEEPS:   sweeps_reg = data & 31'hFFFF;
            CFG_THRESH:   thresh_w = data;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (queued_items.size() != 0 || item.valid || results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(logic [30:0] lasso, logic [30:0] ridge, logic [30:0] ns,
                              logic [30:0] nf, logic [30:0] lim, logic [30:0] thr);
        drain();
        repeat (20) @(posedge clk);
        write_reg(CFG_LASSO, lasso);
        write_reg(CFG_RIDGE, ridge);
        write_reg(CFG_SAMPLES, ns);
        write_reg(CFG_FEATURES, nf);
        write_reg(CFG_SWEEPS, lim);
        write_reg(CFG_THRESH, thr);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int nf_eff, ns_val, fsel, r;
        item.valid = 1'b0;
        item.op = OP_FEATURE;
        item.row = '0;
        item.column = '0;
        item.value = '0;
        result.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        for (int i = 0; i < 8; i++)
            coef[i] = 0;
        bias_q = 0;
        lasso_w = 0;
        ridge_w = 0;
        thresh_w = 0;
        samples_reg = 256;
        features_reg = 8;
        sweeps_reg = 1000;
        stall_pat = 16'hA5C3;
        calm = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // column 0 and targets for the first 32 rows, other columns for the first 8
        for (int n = 0; n < 32; n++)
        begin
            push_item(OP_FEATURE, 8'(n), 3'd0, pick_value());
            push_item(OP_TARGET, 8'(n), 3'd0, pick_value());
        end
        for (int n = 0; n < 8; n++)
            for (int c = 1; c < 8; c++)
                push_item(OP_FEATURE, 8'(n), 3'(c), pick_value());

        // threshold that stops after one sweep
        set_config(31'd0, 31'd0, 31'd32, 31'd1, 31'd65535, 31'h7FFFFFFF);
        push_item(OP_RUN, 8'd0, 3'd0, 32'sd0);
        // zero counts act as one, maximum penalties
        set_config(31'h7FFFFFFF, 31'h7FFFFFFF, 31'd1, 31'd0, 31'd0, 31'd0);
        push_item(OP_RUN, 8'hFF, 3'd7, 32'sh7FFFFFFF);
        // all-zero column gives a zero denominator; feature count above range
        set_config(31'h10000, 31'd0, 31'd8, 31'd15, 31'd3, 31'h100);
        for (int n = 0; n < 8; n++)
            push_item(OP_FEATURE, 8'(n), 3'd7, 32'sd0);
        push_item(OP_FEATURE, 8'hFF, 3'd7, 32'sh80000000);
        push_item(OP_UNUSED, 8'hAA, 3'd5, 32'sh12345678);
        push_item(OP_RUN, 8'd0, 3'd0, 32'sd0);
        // partial row count
        set_config(31'h100, 31'h100, 31'd24, 31'd1, 31'd2, 31'd0);
        push_item(OP_RUN, 8'd0, 3'd0, 32'sd0);

        for (int p = 0; p < 12; p++)
        begin
            fsel = $urandom_range(0, 15);
            nf_eff = fsel == 0 ? 1 : (fsel > 8 ? 8 : fsel);
            if (nf_eff > 1)
                ns_val = $urandom_range(0, 8);
            else
                ns_val = $urandom_range(0, 32);
            set_config(pick_weight(), pick_weight(), 31'(ns_val), 31'(fsel),
                       31'($urandom_range(0, 6)),
                       ($urandom_range(0, 1) == 0) ? 31'd0 : pick_weight());
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 6; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    push_item(OP_UNUSED, 8'($urandom()), 3'($urandom()), $urandom());
                else if (r < 30)
                    push_item(OP_TARGET, 8'($urandom()), 3'($urandom()), pick_value());
                else if (r < 88)
                    push_item(OP_FEATURE, 8'($urandom()), 3'($urandom()), pick_value());
                else
                    push_item(OP_RUN, 8'($urandom()), 3'($urandom()), $urandom());
            end
            push_item(OP_RUN, 8'd0, 3'd0, 32'sd0);
        end

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
